[rtl/core/cfra_pkg.sv]
package cfra_pkg;

   localparam int unsigned OP_W     = 3;
   localparam int unsigned ADDR_W   = 7;
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned HALF_W   = 16;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned RVAL_W   = 64;

   localparam logic ACT_REQUEST  = 1'b0;
   localparam logic ACT_RESPONSE = 1'b1;

   localparam logic [OP_W-1:0] OP_READ16  = 3'd0;
   localparam logic [OP_W-1:0] OP_WRITE16 = 3'd1;
   localparam logic [OP_W-1:0] OP_READ32  = 3'd2;
   localparam logic [OP_W-1:0] OP_WRITE32 = 3'd3;
   localparam logic [OP_W-1:0] OP_READ64  = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CRC_ERR  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_XFER_ERR = 2'd2;

   localparam logic [ADDR_W-1:0] ADDR_MASK = 7'h7F;
   localparam logic [7:0]        WRITE_FLAG = 8'h80;

   typedef struct packed {
      logic              action;
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] write_value;
      logic [DATA_W-1:0] rx_frame;
      logic              transfer_ok;
   } req_type;

   typedef struct packed {
      logic                tx_valid;
      logic [DATA_W-1:0]   tx_frame;
      logic                done_res;
      logic [STATUS_W-1:0] status;
      logic [RVAL_W-1:0]   read_value;
   } rsp_type;

   // Contribution of each message bit to the CRC-8 (polynomial 0x07, init 0).
   // The CRC is linear, so the remainder is the XOR of the columns of set bits.
   localparam logic [7:0] CRC_COL [24] = '{
      8'h07, 8'h0E, 8'h1C, 8'h38, 8'h70, 8'hE0, 8'hC7, 8'h89,
      8'h15, 8'h2A, 8'h54, 8'hA8, 8'h57, 8'hAE, 8'h5B, 8'hB6,
      8'h6B, 8'hD6, 8'hAB, 8'h51, 8'hA2, 8'h43, 8'h86, 8'h0B
   };

   function automatic logic [7:0] crc8_24(input logic [23:0] v);
      logic [7:0] crc;
      crc = 8'h00;
      for (int i = 0; i < 24; i++) begin
         if (v[i]) begin
            crc = crc ^ CRC_COL[i];
         end
      end
      return crc;
   endfunction

endpackage

[rtl/core/cfra_in_stage.sv]
module cfra_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cfra_pkg::req_type req_data,
   input  logic             take,
   output logic             item_valid,
   output cfra_pkg::req_type item
);

   logic             valid_ff;
   logic             valid_in;
   cfra_pkg::req_type item_ff;

   // The stage refills in the same cycle that the engine takes its word.
   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[rtl/core/cfra_engine.sv]
module cfra_engine #(
   parameter int unsigned MAX_WORDS = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  cfra_pkg::req_type  item,
   output cfra_pkg::rsp_type  result
);

   localparam int unsigned IDX_W = (MAX_WORDS > 2) ? 2 : 1;
   localparam int unsigned CNT_W = IDX_W + 1;
   localparam int unsigned ASM_W = cfra_pkg::HALF_W * MAX_WORDS;

   logic                          busy_ff, busy_in;
   logic [cfra_pkg::OP_W-1:0]     op_ff, op_in;
   logic [cfra_pkg::ADDR_W-1:0]   base_ff, base_in;
   logic [cfra_pkg::DATA_W-1:0]   pend_ff, pend_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [ASM_W-1:0]              asm_ff, asm_in;

   logic                          wr_op;
   logic [CNT_W-1:0]              words;
   logic                          last_word;
   logic                          crc_good;
   logic [ASM_W-1:0]              asm_merged;
   logic [cfra_pkg::DATA_W-1:0]   frame;

   function automatic logic is_write(input logic [cfra_pkg::OP_W-1:0] op);
      return (op == cfra_pkg::OP_WRITE16) || (op == cfra_pkg::OP_WRITE32);
   endfunction

   always_comb begin
      logic [cfra_pkg::ADDR_W-1:0] addr;
      logic [cfra_pkg::HALF_W-1:0] half;
      logic [23:0]                 head;
      addr = (base_in + cfra_pkg::ADDR_W'(idx_in)) & cfra_pkg::ADDR_MASK;
      half = (idx_in == '0) ? pend_in[cfra_pkg::HALF_W-1:0]
                            : pend_in[cfra_pkg::DATA_W-1:cfra_pkg::HALF_W];
      if (is_write(op_in)) begin
         head = {(8'(addr) | cfra_pkg::WRITE_FLAG), half};
      end else begin
         head = {8'(addr), 16'h0000};
      end
      frame = {head, cfra_pkg::crc8_24(head)};
   end

   assign wr_op = is_write(op_ff);

   always_comb begin
      priority if (op_ff == cfra_pkg::OP_READ64) begin
         words = CNT_W'(MAX_WORDS);
      end else if (op_ff >= cfra_pkg::OP_READ32) begin
         words = CNT_W'(2);
      end else begin
         words = CNT_W'(1);
      end
   end

   assign last_word = (CNT_W'(idx_ff) + CNT_W'(1)) >= words;
   assign crc_good  = cfra_pkg::crc8_24(item.rx_frame[31:8]) == item.rx_frame[7:0];

   always_comb begin
      asm_merged = asm_ff;
      asm_merged[cfra_pkg::HALF_W*idx_ff +: cfra_pkg::HALF_W] = item.rx_frame[23:8];
   end

   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      base_in = base_ff;
      pend_in = pend_ff;
      idx_in  = idx_ff;
      asm_in  = asm_ff;
      result  = '0;
      if (fire) begin
         if (item.action == cfra_pkg::ACT_REQUEST) begin
            // Undefined op codes leave everything alone and answer with zeros.
            if (item.op <= cfra_pkg::OP_READ64) begin
               busy_in         = 1'b1;
               op_in           = item.op;
               base_in         = item.address;
               pend_in         = item.write_value;
               idx_in          = '0;
               asm_in          = '0;
               result.tx_valid = 1'b1;
            end
         end else if (busy_ff) begin
            priority if (!item.transfer_ok) begin
               busy_in         = 1'b0;
               result.done_res = 1'b1;
               result.status   = cfra_pkg::STATUS_XFER_ERR;
            end else if (!wr_op && !crc_good) begin
               busy_in         = 1'b0;
               result.done_res = 1'b1;
               result.status   = cfra_pkg::STATUS_CRC_ERR;
            end else if (last_word) begin
               busy_in         = 1'b0;
               result.done_res = 1'b1;
               result.status   = cfra_pkg::STATUS_OK;
               if (!wr_op) begin
                  result.read_value = cfra_pkg::RVAL_W'(asm_merged);
               end
            end else begin
               if (!wr_op) begin
                  asm_in = asm_merged;
               end
               idx_in          = idx_ff + IDX_W'(1);
               result.tx_valid = 1'b1;
            end
         end
      end
      if (result.tx_valid) begin
         result.tx_frame = frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      base_ff <= base_in;
      pend_ff <= pend_in;
      idx_ff  <= idx_in;
      asm_ff  <= asm_in;
   end

endmodule

[rtl/core/crc_framed_register_access.sv]
// Channel   Ports                          Word
// request   req_valid, req_ready, req_data   cfra_pkg::req_type
// response  rsp_valid, rsp_ready, rsp_data   cfra_pkg::rsp_type
//
// Every request word yields exactly one response word; it passes through the input
// register and then the response register. While the response side does not stall,
// the block takes one word per cycle.
// The input register feeds a single pass of CRC and sequencing logic into the
// response register. Reset clears the busy flag and both valid flags.
// A stalled response holds the engine and, once the input register is full,
// drops req_ready.
module crc_framed_register_access #(
   parameter int unsigned MAX_WORDS = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cfra_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cfra_pkg::rsp_type  rsp_data
);

   logic              rsp_valid_ff, rsp_valid_in;
   cfra_pkg::rsp_type rsp_data_ff;
   logic              advance;
   logic              item_valid;
   cfra_pkg::req_type item;
   logic              fire;
   cfra_pkg::rsp_type result;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign fire    = item_valid && advance;

   cfra_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .take       (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   cfra_engine #(
      .MAX_WORDS (MAX_WORDS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .result (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[sim/tb_crc_framed_register_access.sv]
module tb_crc_framed_register_access;

   localparam int unsigned N_WORDS      = 4;
   localparam int unsigned RANDOM_ITEMS = 1300;
   localparam int unsigned DRAIN_EVERY  = 300;
   localparam int unsigned TAIL_CYCLES  = 20;
   localparam int unsigned CYCLE_LIMIT  = 500000;

   localparam logic [cfra_pkg::OP_W-1:0] OP_FIRST_UNDEF = 3'd5;
   localparam logic [cfra_pkg::OP_W-1:0] OP_LAST_UNDEF  = 3'd7;

   typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_LONG} stall_mode_type;

   typedef struct {
      cfra_pkg::req_type word;
      bit                drain;
   } outgoing_type;

   logic              clock;
   logic              reset;
   logic              req_valid = 1'b0;
   logic              req_ready;
   cfra_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   cfra_pkg::rsp_type rsp_data;

   crc_framed_register_access #(.MAX_WORDS(N_WORDS)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   outgoing_type      outgoing_q[$];
   cfra_pkg::rsp_type reply_q[$];
   int unsigned    issued_count = 0;
   int unsigned    taken_count  = 0;
   int unsigned    error_count  = 0;
   int unsigned    cycle_count  = 0;
   int unsigned    gap_left     = 0;
   int unsigned    burst_left   = 1;
   int unsigned    mode_left    = 0;
   int unsigned    hold_left    = 0;
   stall_mode_type stall_mode   = STALL_NONE;

   int unsigned n_started = 0;
   int unsigned n_replies = 0;
   int unsigned n_ignored = 0;
   int unsigned n_ok      = 0;
   int unsigned n_crc     = 0;
   int unsigned n_xfer    = 0;

   // Shadow of the link state.
   bit                          model_busy  = 1'b0;
   logic [cfra_pkg::OP_W-1:0]   model_op    = '0;
   logic [cfra_pkg::ADDR_W-1:0] model_base  = '0;
   logic [cfra_pkg::DATA_W-1:0] model_value = '0;
   logic [1:0]                  model_index = '0;
   logic [cfra_pkg::RVAL_W-1:0] model_read  = '0;

   function automatic logic [7:0] crc8_msb_first(input logic [23:0] v);
      logic [7:0] crc;
      logic       fb;
      crc = 8'h00;
      for (int i = 23; i >= 0; i--) begin
         fb  = crc[7] ^ v[i];
         crc = {crc[6:0], 1'b0};
         if (fb) begin
            crc = crc ^ 8'h07;
         end
      end
      return crc;
   endfunction

   function automatic int unsigned op_word_count(input logic [cfra_pkg::OP_W-1:0] op);
      if (op == cfra_pkg::OP_READ64) begin
         return N_WORDS;
      end
      if (op == cfra_pkg::OP_READ32 || op == cfra_pkg::OP_WRITE32) begin
         return 2;
      end
      return 1;
   endfunction

   function automatic bit is_write_op(input logic [cfra_pkg::OP_W-1:0] op);
      return op == cfra_pkg::OP_WRITE16 || op == cfra_pkg::OP_WRITE32;
   endfunction

   function automatic logic [cfra_pkg::DATA_W-1:0] next_tx_frame();
      logic [cfra_pkg::ADDR_W-1:0] a;
      logic [15:0]                 half;
      logic [23:0]                 head;
      a = model_base + cfra_pkg::ADDR_W'(model_index);
      if (is_write_op(model_op)) begin
         half = (model_index == 2'd0) ? model_value[15:0] : model_value[31:16];
         head = {(8'(a) | cfra_pkg::WRITE_FLAG), half};
      end else begin
         head = {1'b0, a, 16'h0000};
      end
      return {head, crc8_msb_first(head)};
   endfunction

   function automatic cfra_pkg::rsp_type predict_reply(input cfra_pkg::req_type r);
      cfra_pkg::rsp_type e;
      e = '0;
      if (r.action == cfra_pkg::ACT_REQUEST) begin
         if (r.op > cfra_pkg::OP_READ64) begin
            n_ignored++;
            return e;
         end
         model_busy  = 1'b1;
         model_op    = r.op;
         model_base  = r.address;
         model_value = r.write_value;
         model_index = '0;
         model_read  = '0;
         n_started++;
         e.tx_valid = 1'b1;
         e.tx_frame = next_tx_frame();
         return e;
      end
      if (!model_busy) begin
         n_ignored++;
         return e;
      end
      n_replies++;
      if (!r.transfer_ok) begin
         model_busy = 1'b0;
         e.done_res = 1'b1;
         e.status   = cfra_pkg::STATUS_XFER_ERR;
         n_xfer++;
         return e;
      end
      if (!is_write_op(model_op)) begin
         if (crc8_msb_first(r.rx_frame[31:8]) != r.rx_frame[7:0]) begin
            model_busy = 1'b0;
            e.done_res = 1'b1;
            e.status   = cfra_pkg::STATUS_CRC_ERR;
            n_crc++;
            return e;
         end
         model_read = model_read |
                      (cfra_pkg::RVAL_W'(r.rx_frame[23:8]) << (16 * model_index));
      end
      if (int'(model_index) + 1 >= int'(op_word_count(model_op))) begin
         model_busy   = 1'b0;
         e.done_res   = 1'b1;
         e.status     = cfra_pkg::STATUS_OK;
         e.read_value = is_write_op(model_op) ? '0 : model_read;
         n_ok++;
         return e;
      end
      model_index = model_index + 2'd1;
      e.tx_valid  = 1'b1;
      e.tx_frame  = next_tx_frame();
      return e;
   endfunction

   function automatic cfra_pkg::req_type request_word(
         input logic [cfra_pkg::OP_W-1:0]   op,
         input logic [cfra_pkg::ADDR_W-1:0] addr,
         input logic [cfra_pkg::DATA_W-1:0] value);
      cfra_pkg::req_type r;
      r.action      = cfra_pkg::ACT_REQUEST;
      r.op          = op;
      r.address     = addr;
      r.write_value = value;
      r.rx_frame    = $urandom;
      r.transfer_ok = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic cfra_pkg::req_type response_word(
         input logic [cfra_pkg::DATA_W-1:0] rx, input logic ok);
      cfra_pkg::req_type r;
      r.action      = cfra_pkg::ACT_RESPONSE;
      r.op          = cfra_pkg::OP_W'($urandom);
      r.address     = cfra_pkg::ADDR_W'($urandom);
      r.write_value = $urandom;
      r.rx_frame    = rx;
      r.transfer_ok = ok;
      return r;
   endfunction

   // Received frame with a random first byte and a correct CRC.
   function automatic logic [cfra_pkg::DATA_W-1:0] good_rx(input logic [15:0] data);
      logic [23:0] head;
      head = {8'($urandom), data};
      return {head, crc8_msb_first(head)};
   endfunction

   function automatic logic [cfra_pkg::DATA_W-1:0] corrupt_rx();
      return good_rx(16'($urandom)) ^ (32'h1 << $urandom_range(0, 31));
   endfunction

   function automatic logic [cfra_pkg::ADDR_W-1:0] pick_address();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         return '0;
      end
      if (roll < 15) begin
         return cfra_pkg::ADDR_MASK - cfra_pkg::ADDR_W'($urandom_range(0, 3));
      end
      return cfra_pkg::ADDR_W'($urandom);
   endfunction

   function automatic logic [cfra_pkg::DATA_W-1:0] pick_value();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         return '0;
      end
      if (roll < 16) begin
         return '1;
      end
      return $urandom;
   endfunction

   function automatic logic [cfra_pkg::OP_W-1:0] pick_defined_op();
      return cfra_pkg::OP_W'($urandom_range(cfra_pkg::OP_READ16, cfra_pkg::OP_READ64));
   endfunction

   task automatic queue_word(input cfra_pkg::req_type r, input bit drain = 1'b0);
      outgoing_type o;
      o.word  = r;
      o.drain = drain || (outgoing_q.size() % DRAIN_EVERY == 0 && outgoing_q.size() != 0);
      outgoing_q.push_back(o);
   endtask

   // A request followed by its responses; now and then one fails or the
   // operation is left unfinished so that the next request interrupts it.
   task automatic queue_sequence();
      logic [cfra_pkg::OP_W-1:0] op;
      int unsigned               n;
      int unsigned               roll;
      bit                        wr;
      op = pick_defined_op();
      n  = op_word_count(op);
      wr = is_write_op(op);
      queue_word(request_word(op, pick_address(), pick_value()));
      for (int w = 0; w < int'(n); w++) begin
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            queue_word(response_word(good_rx(16'($urandom)), 1'b0));
            break;
         end
         if (roll < 8 && !wr) begin
            queue_word(response_word(corrupt_rx(), 1'b1));
            break;
         end
         if (roll < 11) begin
            break;
         end
         queue_word(response_word(wr ? $urandom : good_rx(16'($urandom)), 1'b1));
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d words still expected", cycle_count,
               reply_q.size());
      $display("DONE: errors detected");
      $finish;
   end

   // Sender: bursts of words separated by idle gaps.
   always @(negedge clock) begin : drive
      outgoing_type nxt;
      logic         next_valid;
      if (!reset && !(req_valid && taken_count != issued_count)) begin
         next_valid = 1'b0;
         if (gap_left != 0) begin
            gap_left--;
         end else if (outgoing_q.size() != 0 &&
                      !(outgoing_q[0].drain && reply_q.size() != 0)) begin
            nxt = outgoing_q.pop_front();
            req_data <= nxt.word;
            next_valid = 1'b1;
            issued_count++;
            if (burst_left > 1) begin
               burst_left--;
            end else if ($urandom_range(0, 4) == 0) begin
               burst_left = $urandom_range(40, 80);
               gap_left   = 0;
            end else begin
               burst_left = $urandom_range(1, 16);
               gap_left   = $urandom_range(1, 10);
            end
         end
         req_valid <= next_valid;
      end
   end

   // Receiver: switches between always ready, coin flips and long stalls.
   always @(negedge clock) begin : stall_pattern
      logic ready_next;
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 2));
         mode_left  = $urandom_range(50, 300);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         STALL_NONE: begin
            ready_next = 1'b1;
         end
         STALL_COIN: begin
            ready_next = 1'($urandom_range(0, 1));
         end
         default: begin
            if (hold_left != 0) begin
               hold_left--;
               ready_next = rsp_ready;
            end else begin
               ready_next = !rsp_ready;
               hold_left  = rsp_ready ? $urandom_range(1, 20) : $urandom_range(0, 3);
            end
         end
      endcase
      rsp_ready <= ready_next;
   end

   always @(posedge clock) begin : observe
      cfra_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            reply_q.push_back(predict_reply(req_data));
            taken_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (reply_q.size() == 0) begin
               $error("response word %h arrived with nothing expected", rsp_data);
               error_count++;
            end else begin
               want = reply_q.pop_front();
               check_field("tx_valid", want.tx_valid, rsp_data.tx_valid);
               check_field("tx_frame", want.tx_frame, rsp_data.tx_frame);
               check_field("done_res", want.done_res, rsp_data.done_res);
               check_field("status", want.status, rsp_data.status);
               check_field("read_value", want.read_value, rsp_data.read_value);
            end
         end
      end
   end

   initial begin : main
      int unsigned directed_count;
      int unsigned pick;
      reset = 1'b1;

      // Directed part. Responses while idle are ignored.
      queue_word(response_word(good_rx(16'hFFFF), 1'b1));
      queue_word(request_word(cfra_pkg::OP_READ16, 7'd0, $urandom));
      queue_word(response_word(good_rx(16'hFFFF), 1'b1));
      queue_word(request_word(cfra_pkg::OP_WRITE16, cfra_pkg::ADDR_MASK, 32'hFFFF_FFFF));
      queue_word(response_word($urandom, 1'b1));
      // Write32 at the top address wraps to address zero; a bad CRC in a
      // write response does not matter.
      queue_word(request_word(cfra_pkg::OP_WRITE32, cfra_pkg::ADDR_MASK, 32'h0000_FFFF));
      queue_word(response_word(corrupt_rx(), 1'b1));
      queue_word(response_word(corrupt_rx(), 1'b1));
      queue_word(request_word(cfra_pkg::OP_READ64, 7'd125, 32'h0));
      queue_word(response_word(good_rx(16'h0000), 1'b1));
      queue_word(response_word(good_rx(16'hFFFF), 1'b1));
      queue_word(response_word(good_rx(16'hA5A5), 1'b1));
      queue_word(response_word(good_rx(16'h5A5A), 1'b1));
      queue_word(request_word(cfra_pkg::OP_READ32, 7'd126, $urandom));
      queue_word(response_word(good_rx(16'h1234), 1'b1));
      queue_word(response_word(corrupt_rx(), 1'b1));
      queue_word(request_word(cfra_pkg::OP_WRITE32, 7'd0, 32'hFFFF_0000));
      queue_word(response_word($urandom, 1'b1));
      queue_word(response_word(good_rx(16'h0F0F), 1'b0));
      queue_word(request_word(OP_FIRST_UNDEF, cfra_pkg::ADDR_MASK, 32'hFFFF_FFFF));
      queue_word(request_word(OP_LAST_UNDEF, 7'd0, 32'h0));
      // A new request cuts the running read short.
      queue_word(request_word(cfra_pkg::OP_READ64, 7'd64, $urandom));
      queue_word(response_word(good_rx(16'hBEEF), 1'b1));
      queue_word(request_word(cfra_pkg::OP_WRITE16, 7'd1, 32'h0));
      queue_word(response_word(good_rx(16'h0000), 1'b1));
      queue_word(response_word($urandom, 1'b0));
      directed_count = outgoing_q.size();

      // Random part; the first random word waits for the directed part to drain.
      queue_sequence();
      outgoing_q[directed_count].drain = 1'b1;
      while (outgoing_q.size() < directed_count + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            queue_sequence();
         end else if (pick < 85) begin
            queue_word(request_word(pick_defined_op(), pick_address(), pick_value()));
            repeat ($urandom_range(1, 3)) begin
               queue_word(response_word($urandom, 1'($urandom_range(0, 1))));
            end
         end else if (pick < 92) begin
            queue_word(request_word(
               cfra_pkg::OP_W'($urandom_range(OP_FIRST_UNDEF, OP_LAST_UNDEF)),
               cfra_pkg::ADDR_W'($urandom), $urandom));
         end else begin
            queue_word(response_word($urandom, 1'($urandom_range(0, 1))));
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (outgoing_q.size() != 0 || taken_count != issued_count || reply_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d words: %0d operations started, %0d responses while busy, %0d ignored",
               taken_count, n_started, n_replies, n_ignored);
      $display("finished: %0d ok, %0d response CRC errors, %0d transfer failures",
               n_ok, n_crc, n_xfer);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/cfra_pkg.sv
rtl/core/cfra_in_stage.sv
rtl/core/cfra_engine.sv
rtl/core/crc_framed_register_access.sv
sim/tb_crc_framed_register_access.sv
